FILE: hdl/assert_macros.svh
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CHK_ON_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every rising clock edge, reset included.
`define CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tbaq_pkg.sv
package tbaq_pkg;

	localparam int PERIOD_W = 24;
	localparam int CAP_W    = 16;
	localparam int CONC_W   = 16;
	localparam int QLIM_W   = 7;
	localparam int TAG_W    = 16;
	localparam int TOK_W    = 16;
	localparam int REJ_W    = 32;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CONC = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Q_LIMIT  = 2'd3;

	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd1000;
	localparam logic [CAP_W-1:0]    CAPACITY_RST = 16'd100;
	localparam logic [CONC_W-1:0]   MAX_CONC_RST = 16'd8;
	localparam logic [QLIM_W-1:0]   Q_LIMIT_RST  = 7'd64;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_DISPATCH = 2'd1,
		ACT_QUEUE    = 2'd2,
		ACT_REJECT   = 2'd3
	} action_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [CAP_W-1:0]    capacity;
		logic [CONC_W-1:0]   max_conc;
		logic [QLIM_W-1:0]   q_limit;
	} cfg_t;

	// classified event word
	typedef struct packed {
		logic             done;     // completion
		logic             two_tok;  // arrival of a write
		logic [TAG_W-1:0] tag;
	} evt_t;

	typedef struct packed {
		action_t          action;
		logic [TAG_W-1:0] tag;
		logic             wr;
		logic [TOK_W-1:0] tokens;
		logic [REJ_W-1:0] rejects;
	} res_t;

endpackage

FILE: hdl/tbaq_ram.sv
module tbaq_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/tbaq_front.sv
module tbaq_front #(
	parameter int TIME_BITS = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 kind,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [15:0]          request_tag,
	input  logic                 write_flag,
	output logic                 ev_valid,
	input  logic                 ev_take,
	output tbaq_pkg::evt_t       ev,
	output logic [TIME_BITS-1:0] ev_time
);
	import tbaq_pkg::*;

	evt_t                 evt_q  [2];
	logic [TIME_BITS-1:0] time_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 do_push;
	logic                 do_pop;
	evt_t                 cls;

	always_comb begin
		cls.done    = kind;
		cls.two_tok = !kind && write_flag;
		cls.tag     = request_tag;
	end

	assign full     = (cnt_q == 2'd2);
	assign ev_valid = (cnt_q != 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = ev_take && ev_valid;
	assign ev       = evt_q[rd_ptr_q];
	assign ev_time  = time_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			evt_q[wr_ptr_q]  <= cls;
			time_q[wr_ptr_q] <= event_time;
		end
	end

endmodule

FILE: hdl/tbaq_outq.sv
module tbaq_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_push,
	output logic           res_full,
	input  tbaq_pkg::res_t din,
	output logic           empty,
	input  logic           pop,
	output tbaq_pkg::res_t dout
);
	import tbaq_pkg::*;

	res_t       word_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;
	assign dout     = word_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			word_q[wr_ptr_q] <= din;
		end
	end

endmodule

FILE: hdl/tbaq_back.sv
module tbaq_back #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbaq_pkg::cfg_t       cfg,
	input  logic                 ev_valid,
	input  tbaq_pkg::evt_t       ev,
	input  logic [TIME_BITS-1:0] ev_time,
	output logic                 ev_take,
	input  logic                 res_full,
	output logic                 res_push,
	output tbaq_pkg::res_t       res
);
	import tbaq_pkg::*;

	localparam int ITERS = (TIME_BITS + 1) / 2;
	localparam int DW    = 2 * ITERS;
	localparam int SW    = $clog2(ITERS + 1);
	localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int LW    = (CW > QLIM_W) ? CW : QLIM_W;
	localparam int EW    = (DW > 17) ? DW : 17;
	localparam int ENT_W = TAG_W + 1;
	localparam logic [16:0] EARN_CLAMP = 17'h1FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_APPLY,
		ST_DECIDE
	} state_t;

	state_t               state_q;
	logic [SW-1:0]        step_q;
	logic [TOK_W-1:0]     token_q;
	logic [TIME_BITS-1:0] last_q;
	logic [CONC_W-1:0]    active_q;
	logic [AW-1:0]        head_q;
	logic [AW-1:0]        tail_q;
	logic [CW-1:0]        wcount_q;
	logic [REJ_W-1:0]     rej_q;

	evt_t                 evt_q;
	logic [TIME_BITS-1:0] now_q;
	logic [DW-1:0]        dq_q;     // dividend in, quotient out
	logic [PERIOD_W-1:0]  rem_q;

	// refill setup
	logic                 skip;
	logic [TIME_BITS-1:0] delta;

	// two restoring steps a cycle
	logic [PERIOD_W:0]    t1, t2;
	logic [PERIOD_W-1:0]  r1, r2;
	logic                 b1, b2;

	// refill apply
	logic [EW-1:0]        q_ext;
	logic [16:0]          earned_c;
	logic [17:0]          fill_sum;
	logic [TOK_W-1:0]     token_fill;
	logic [TIME_BITS-1:0] last_fill;

	// admission decision
	logic [ENT_W-1:0]     entry;
	logic                 two;
	logic [TOK_W-1:0]     cost;
	logic                 can_go;
	logic [LW-1:0]        q_lim;
	logic                 q_room;
	logic [AW-1:0]        head_nx;
	logic [AW-1:0]        tail_nx;
	logic                 fire;
	logic                 ram_we;
	logic [TOK_W-1:0]     token_nx;
	logic [REJ_W-1:0]     rej_nx;

	assign skip  = (cfg.period == '0) || (ev_time <= last_q);
	assign delta = ev_time - last_q;

	always_comb begin
		t1 = {rem_q, dq_q[DW-1]};
		b1 = (t1 >= {1'b0, cfg.period});
		r1 = b1 ? PERIOD_W'(t1 - {1'b0, cfg.period}) : t1[PERIOD_W-1:0];
		t2 = {r1, dq_q[DW-2]};
		b2 = (t2 >= {1'b0, cfg.period});
		r2 = b2 ? PERIOD_W'(t2 - {1'b0, cfg.period}) : t2[PERIOD_W-1:0];
	end

	always_comb begin
		q_ext      = EW'(dq_q);
		earned_c   = (q_ext > EW'(EARN_CLAMP)) ? EARN_CLAMP : q_ext[16:0];
		fill_sum   = {2'b00, token_q} + {1'b0, earned_c};
		token_fill = (fill_sum > {2'b00, cfg.capacity}) ? cfg.capacity
			: fill_sum[TOK_W-1:0];
		// last + earned * period is now less the remainder
		last_fill  = now_q - TIME_BITS'(rem_q);
	end

	tbaq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_wait_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata({evt_q.tag, evt_q.two_tok}),
		.raddr(head_q),
		.rdata(entry)
	);

	always_comb begin
		two     = evt_q.done ? entry[0] : evt_q.two_tok;
		cost    = two ? TOK_W'(2) : TOK_W'(1);
		can_go  = (active_q < cfg.max_conc) && (token_q >= cost);
		q_lim   = (LW'(cfg.q_limit) < LW'(QUEUE_DEPTH)) ? LW'(cfg.q_limit)
			: LW'(QUEUE_DEPTH);
		q_room  = (LW'(wcount_q) < q_lim);
		head_nx = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(head_q + 1'b1);
		tail_nx = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(tail_q + 1'b1);
		rej_nx  = (rej_q == '1) ? rej_q : rej_q + 1'b1;

		fire     = (state_q == ST_DECIDE) && !res_full;
		ram_we   = fire && !evt_q.done && !can_go && q_room;
		token_nx = token_q;
		res.action  = ACT_NONE;
		res.tag     = '0;
		res.wr      = 1'b0;
		res.rejects = rej_q;

		if (!evt_q.done) begin
			res.tag = evt_q.tag;
			res.wr  = evt_q.two_tok;
			if (can_go) begin
				res.action = ACT_DISPATCH;
				token_nx   = token_q - cost;
			end else if (q_room) begin
				res.action = ACT_QUEUE;
			end else begin
				res.action  = ACT_REJECT;
				res.rejects = rej_nx;
			end
		end else if (wcount_q != '0 && can_go) begin
			res.action = ACT_DISPATCH;
			res.tag    = entry[ENT_W-1:1];
			res.wr     = entry[0];
			token_nx   = token_q - cost;
		end
		res.tokens = token_nx;
	end

	assign ev_take  = (state_q == ST_IDLE) && ev_valid;
	assign res_push = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			token_q  <= '0;
			last_q   <= '0;
			active_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			wcount_q <= '0;
			rej_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ev_valid) begin
						if (ev.done && active_q != '0) begin
							active_q <= active_q - 1'b1;
						end
						step_q  <= SW'(ITERS - 1);
						state_q <= skip ? ST_APPLY : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_APPLY;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_APPLY: begin
					if (dq_q != '0) begin
						token_q <= token_fill;
						last_q  <= last_fill;
					end
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (fire) begin
						token_q <= token_nx;
						rej_q   <= res.rejects;
						if (res.action == ACT_DISPATCH) begin
							active_q <= active_q + 1'b1;
						end
						if (res.action == ACT_QUEUE) begin
							tail_q   <= tail_nx;
							wcount_q <= wcount_q + 1'b1;
						end
						if (res.action == ACT_DISPATCH && evt_q.done) begin
							head_q   <= head_nx;
							wcount_q <= wcount_q - 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ev_take) begin
			evt_q <= ev;
			now_q <= ev_time;
			rem_q <= '0;
			// a zero dividend gives no refill
			dq_q  <= skip ? '0 : DW'(delta);
		end else if (state_q == ST_DIV) begin
			rem_q <= r2;
			dq_q  <= {dq_q[DW-3:0], b1, b2};
		end
	end

endmodule

FILE: hdl/token_bucket_admission_queue_unit.sv
// Channel   Handshake         Word
// event     push / full       kind, event_time, request_tag, write_flag
// result    empty / pop       action, out_tag, out_write, tokens_left, reject_total
// config    cfg_we            cfg_index, cfg_data
//
// An event passes through the take, divide, apply and decide states of the back end;
// the refill divider retires two quotient bits a cycle. An event whose time is not
// past the last refill, or that meets a zero period, skips the divider and passes
// only through the take, apply and decide states.
// Two-word queues on the event and result sides let either side stall alone;
// the back end holds its result while the result queue is full.
// arst_n clears all control state and restores the register defaults.
module token_bucket_admission_queue_unit #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 40
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tbaq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tbaq_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic                           kind,
	input  logic [TIME_BITS-1:0]           event_time,
	input  logic [15:0]                    request_tag,
	input  logic                           write_flag,
	output logic                           empty,
	input  logic                           pop,
	output tbaq_pkg::action_t              action,
	output logic [15:0]                    out_tag,
	output logic                           out_write,
	output logic [15:0]                    tokens_left,
	output logic [31:0]                    reject_total
);
	import tbaq_pkg::*;

	cfg_t                 cfg_q;
	logic                 ev_valid;
	logic                 ev_take;
	evt_t                 ev;
	logic [TIME_BITS-1:0] ev_time;
	logic                 res_full;
	logic                 res_push;
	res_t                 res;
	res_t                 head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period   <= PERIOD_RST;
			cfg_q.capacity <= CAPACITY_RST;
			cfg_q.max_conc <= MAX_CONC_RST;
			cfg_q.q_limit  <= Q_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD:   cfg_q.period   <= cfg_data[PERIOD_W-1:0];
				REG_CAPACITY: cfg_q.capacity <= cfg_data[CAP_W-1:0];
				REG_MAX_CONC: cfg_q.max_conc <= cfg_data[CONC_W-1:0];
				REG_Q_LIMIT:  cfg_q.q_limit  <= cfg_data[QLIM_W-1:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	tbaq_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.event_time (event_time),
		.request_tag(request_tag),
		.write_flag (write_flag),
		.ev_valid   (ev_valid),
		.ev_take    (ev_take),
		.ev         (ev),
		.ev_time    (ev_time)
	);

	tbaq_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIME_BITS  (TIME_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.ev_valid(ev_valid),
		.ev      (ev),
		.ev_time (ev_time),
		.ev_take (ev_take),
		.res_full(res_full),
		.res_push(res_push),
		.res     (res)
	);

	tbaq_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_push(res_push),
		.res_full(res_full),
		.din     (res),
		.empty   (empty),
		.pop     (pop),
		.dout    (head)
	);

	assign action       = head.action;
	assign out_tag      = head.tag;
	assign out_write    = head.wr;
	assign tokens_left  = head.tokens;
	assign reject_total = head.rejects;

endmodule

FILE: hdl/tbaq_checker.sv
`include "assert_macros.svh"

module tbaq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input tbaq_pkg::action_t action,
	input logic [15:0]       out_tag,
	input logic              out_write,
	input logic [15:0]       tokens_left,
	input logic [31:0]       reject_total
);
	import tbaq_pkg::*;

	`CHK_ALWAYS(a_empty_in_reset, !arst_n |-> empty, "result queue not empty in reset")

	`CHK_ON_CLK(a_head_holds, (!empty && !pop) |=> (!empty && $stable(action) && $stable(out_tag) && $stable(tokens_left) && $stable(reject_total)), "waiting result word changed")

	`CHK_ON_CLK(a_rejects_rise, (!empty && pop) |=> (empty || reject_total >= $past(reject_total)), "reject total went down")

	`CHK_ON_CLK(a_none_blank, (!empty && action == ACT_NONE) |-> (out_tag == 16'd0 && !out_write), "no-action word carries a request")

endmodule

bind token_bucket_admission_queue_unit tbaq_checker u_tbaq_checker (.*);

FILE: tb/token_bucket_admission_queue_unit_tb.sv
`timescale 1ns / 100ps

module token_bucket_admission_queue_unit_tb;
	import tbaq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 31;
	localparam int DRAIN_WAIT  = 40;

	// Mirror of the admission controller: bucket, service slots, backlog FIFO.
	class admission_scoreboard;
		logic [23:0] period;
		logic [15:0] capacity;
		logic [15:0] conc_max;
		logic [6:0]  backlog_limit;

		logic [15:0] tokens;
		logic [39:0] refill_stamp;
		logic [15:0] in_service;
		logic [16:0] backlog[64];
		logic [5:0]  bl_head;
		logic [5:0]  bl_tail;
		logic [6:0]  bl_count;
		logic [31:0] reject_cnt;

		res_t expected_q[$];
		int   errors;
		int   words_seen;

		function new();
			period        = PERIOD_RST;
			capacity      = CAPACITY_RST;
			conc_max      = MAX_CONC_RST;
			backlog_limit = Q_LIMIT_RST;
			tokens        = '0;
			refill_stamp  = '0;
			in_service    = '0;
			bl_head       = '0;
			bl_tail       = '0;
			bl_count      = '0;
			reject_cnt    = '0;
			errors        = 0;
			words_seen    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_PERIOD:   period        = data;
				REG_CAPACITY: capacity      = data[15:0];
				REG_MAX_CONC: conc_max      = data[15:0];
				REG_Q_LIMIT:  backlog_limit = data[6:0];
				default: ;
			endcase
		endfunction

		// whole tokens only; the stamp moves by the full earned amount even past the cap
		function void top_up(logic [39:0] now);
			logic [63:0] delta;
			logic [63:0] earned;
			logic [63:0] sum;
			if (period == 0 || now <= refill_stamp)
				return;
			delta  = 64'(now - refill_stamp);
			earned = delta / period;
			if (earned == 0)
				return;
			sum = tokens + earned;
			tokens = (sum > capacity) ? capacity : sum[15:0];
			refill_stamp = 40'(refill_stamp + earned * period);
		endfunction

		function bit fits(logic [1:0] cost);
			return in_service < conc_max && tokens >= cost;
		endfunction

		function void note_event(logic k, logic [39:0] now, logic [15:0] tag, logic wr);
			res_t        r;
			logic [1:0]  cost;
			logic [6:0]  lim;
			logic [16:0] entry;
			r = '0;
			r.action = ACT_NONE;
			if (!k) begin
				cost = wr ? 2'd2 : 2'd1;
				lim = (backlog_limit < 7'd64) ? backlog_limit : 7'd64;
				top_up(now);
				r.tag = tag;
				r.wr  = wr;
				if (fits(cost)) begin
					tokens = tokens - cost;
					in_service = in_service + 1'b1;
					r.action = ACT_DISPATCH;
				end else if (bl_count < lim) begin
					backlog[bl_tail] = {tag, wr};
					bl_tail = bl_tail + 1'b1;
					bl_count = bl_count + 1'b1;
					r.action = ACT_QUEUE;
				end else begin
					if (reject_cnt != '1)
						reject_cnt = reject_cnt + 1'b1;
					r.action = ACT_REJECT;
				end
			end else begin
				if (in_service != 0)
					in_service = in_service - 1'b1;
				top_up(now);
				if (bl_count != 0) begin
					entry = backlog[bl_head];
					cost = entry[0] ? 2'd2 : 2'd1;
					if (fits(cost)) begin
						bl_head = bl_head + 1'b1;
						bl_count = bl_count - 1'b1;
						tokens = tokens - cost;
						in_service = in_service + 1'b1;
						r.action = ACT_DISPATCH;
						r.tag = entry[16:1];
						r.wr  = entry[0];
					end
				end
			end
			r.tokens  = tokens;
			r.rejects = reject_cnt;
			expected_q.push_back(r);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_word(res_t got);
			res_t want;
			words_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("word %0d arrived with nothing outstanding", words_seen));
				return;
			end
			want = expected_q.pop_front();
			if (got.action !== want.action)
				report($sformatf("word %0d action %0h, want %0h", words_seen,
					got.action, want.action));
			if (got.tag !== want.tag)
				report($sformatf("word %0d out_tag %0h, want %0h", words_seen,
					got.tag, want.tag));
			if (got.wr !== want.wr)
				report($sformatf("word %0d out_write %0h, want %0h", words_seen,
					got.wr, want.wr));
			if (got.tokens !== want.tokens)
				report($sformatf("word %0d tokens_left %0h, want %0h", words_seen,
					got.tokens, want.tokens));
			if (got.rejects !== want.rejects)
				report($sformatf("word %0d reject_total %0h, want %0h", words_seen,
					got.rejects, want.rejects));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 push;
	logic                 full;
	logic                 kind;
	logic [39:0]          event_time;
	logic [15:0]          request_tag;
	logic                 write_flag;
	logic                 empty;
	logic                 pop = 1'b0;
	action_t              action;
	logic [15:0]          out_tag;
	logic                 out_write;
	logic [15:0]          tokens_left;
	logic [31:0]          reject_total;

	admission_scoreboard sb = new();
	bit          no_idle = 1'b0;
	logic [39:0] cursor  = '0;
	int          cycle_count = 0;
	res_t        got;

	token_bucket_admission_queue_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.event_time   (event_time),
		.request_tag  (request_tag),
		.write_flag   (write_flag),
		.empty        (empty),
		.pop          (pop),
		.action       (action),
		.out_tag      (out_tag),
		.out_write    (out_write),
		.tokens_left  (tokens_left),
		.reject_total (reject_total)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stalls, word taken at the rising edge
	always @(negedge clk) begin
		pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			got.action  = action;
			got.tag     = out_tag;
			got.wr      = out_write;
			got.tokens  = tokens_left;
			got.rejects = reject_total;
			sb.check_word(got);
		end
	end

	// called at a falling edge, returns at a falling edge with push still high
	task send_event(input logic k, input logic [39:0] t, input logic [15:0] tg, input logic w);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push        <= 1'b1;
		kind        <= k;
		event_time  <= t;
		request_tag <= tg;
		write_flag  <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_event(k, t, tg, w);
		@(negedge clk);
	endtask

	// hold the sender until every outstanding word is back, then let the back end drain
	task settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task set_config(input logic [23:0] per, input logic [15:0] cap,
			input logic [15:0] conc, input logic [6:0] qlim);
		cfg_we <= 1'b1;
		put_reg(REG_PERIOD, per);
		put_reg(REG_CAPACITY, cap);
		put_reg(REG_MAX_CONC, conc);
		put_reg(REG_Q_LIMIT, qlim);
		cfg_we <= 1'b0;
	endtask

	task random_item(input int arrive_pct);
		logic [63:0] step;
		logic [39:0] t;
		int          span;
		int          pick;
		span = (sb.period == 0) ? 1000 : int'(sb.period);
		pick = $urandom_range(0, 99);
		if (pick < 15)
			step = '0;
		else if (pick < 97)
			step = 64'($urandom_range(0, 3) * span + $urandom_range(0, span));
		else
			step = 64'($urandom);
		cursor = cursor + step[39:0];
		t = cursor;
		// occasional stale timestamp, cursor left where it is
		if ($urandom_range(0, 99) < 4 && cursor > span)
			t = cursor - 40'($urandom_range(1, span));
		send_event($urandom_range(0, 99) >= arrive_pct, t, 16'($urandom_range(0, 65535)),
			1'($urandom_range(0, 1)));
	endtask

	task run_phase(input logic [23:0] per, input logic [15:0] cap, input logic [15:0] conc,
			input logic [6:0] qlim, input int n, input int arrive_pct);
		settle();
		set_config(per, cap, conc, qlim);
		repeat (n) random_item(arrive_pct);
	endtask

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_PERIOD;
		cfg_data    = '0;
		kind        = 1'b0;
		event_time  = '0;
		request_tag = '0;
		write_flag  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default registers: empty bucket, so arrivals wait
		send_event(1'b1, 40'd0, 16'h0000, 1'b0);
		send_event(1'b0, 40'd0, 16'hFFFF, 1'b0);
		send_event(1'b0, 40'd0, 16'h0000, 1'b1);
		send_event(1'b1, 40'd1000, 16'h5A5A, 1'b1);
		send_event(1'b1, 40'd1000, 16'h0000, 1'b0);
		send_event(1'b1, 40'd400, 16'hFFFF, 1'b1);
		send_event(1'b1, 40'd3999, 16'h0000, 1'b0);
		send_event(1'b0, 40'd4000, 16'h1234, 1'b0);
		cursor = 40'h00_8000_0000;
		send_event(1'b0, cursor, 16'hA5A5, 1'b1);

		// fill far past a later cap, one slot busy, backlog of two
		settle();
		set_config(24'd1, 16'hFFFF, 16'd1, 7'd2);
		cursor = cursor + 40'd70000;
		send_event(1'b0, cursor, 16'h0F0F, 1'b0);
		send_event(1'b0, cursor, 16'hF0F0, 1'b1);
		send_event(1'b0, cursor, 16'h3C3C, 1'b0);

		// lowered cap: stored count only cut at a refill that earns a token
		settle();
		set_config(24'd1, 16'd5, 16'd1, 7'd2);
		repeat (3) send_event(1'b1, cursor, 16'h0000, 1'b0);
		cursor = cursor + 1'b1;
		send_event(1'b1, cursor, 16'h0000, 1'b0);

		// zero period: bucket frozen, limit above the FIFO depth
		settle();
		set_config(24'd0, 16'd100, 16'd2, 7'd127);
		cursor = cursor + 40'd123456;
		send_event(1'b0, cursor, 16'h8001, 1'b0);
		send_event(1'b0, cursor, 16'h7FFE, 1'b1);
		send_event(1'b1, cursor, 16'h0000, 1'b0);
		send_event(1'b0, cursor + 40'd9, 16'h4242, 1'b0);

		run_phase(24'd1000, 16'd100, 16'd8, 7'd64, 100, 55);
		run_phase(24'd1, 16'hFFFF, 16'hFFFF, 7'd127, 60, 60);
		run_phase(24'hFFFFFF, 16'd1, 16'd1, 7'd127, 120, 85);
		no_idle = 1'b1;
		run_phase(24'($urandom_range(1, 5000)), 16'($urandom_range(1, 300)),
			16'($urandom_range(1, 4)), 7'($urandom_range(1, 10)), 120, 55);
		no_idle = 1'b0;
		run_phase(24'd0, 16'hFFFF, 16'd2, 7'd0, 50, 50);
		run_phase(24'($urandom_range(1, 100000)), 16'($urandom_range(1, 65535)),
			16'($urandom_range(1, 16)), 7'($urandom_range(0, 127)), 60, 55);

		// top of the time range, then a stale stamp
		settle();
		set_config(24'd7, 16'hFFFF, 16'hFFFF, 7'd64);
		send_event(1'b0, 40'hFF_FFFF_FFFF, 16'hFFFF, 1'b1);
		send_event(1'b1, 40'hFF_FFFF_FFFF, 16'h0000, 1'b0);
		send_event(1'b0, 40'h00_0001_2345, 16'h00FF, 1'b0);
		settle();

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tbaq_pkg.sv
hdl/tbaq_ram.sv
hdl/tbaq_front.sv
hdl/tbaq_outq.sv
hdl/tbaq_back.sv
hdl/token_bucket_admission_queue_unit.sv
hdl/tbaq_checker.sv
tb/token_bucket_admission_queue_unit_tb.sv
